// ----- sv/yaw_angle_outer_loop_defines.svh -----
// ----------------------------------------------------------------------------
// Yaw angle outer loop: assertion macros
// Concurrent assertion helpers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef YAW_ANGLE_OUTER_LOOP_DEFINES_SVH
`define YAW_ANGLE_OUTER_LOOP_DEFINES_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge outside reset
`define YAO_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle
`define YAO_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error(msg);

`else

`define YAO_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define YAO_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg)

`endif

`endif

// ----- sv/yao_pkg.sv -----
// ----------------------------------------------------------------------------
// Yaw angle outer loop package
// Field widths, angle constants, sequencer states and shared helpers.
// ----------------------------------------------------------------------------
package yao_pkg;

	// Field widths
	localparam int YAW_W      = 17;
	localparam int GYRO_W     = 20;
	localparam int STEP_W     = 16;
	localparam int GAIN_W     = 16;
	localparam int BIAS_W     = 20;
	localparam int OUT_W      = 24;
	localparam int ERR_W      = 18;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	// Internal widths
	localparam int ANGLE_W = 18;
	localparam int TGT_W   = 19;
	localparam int SUM_W   = 15;
	localparam int WRAP_W  = 20;
	localparam int GDIFF_W = 21;
	localparam int MUL_A_W = 25;
	localparam int MUL_B_W = 19;
	localparam int ACC_W   = MUL_A_W + MUL_B_W;

	// Angle constants, Q8 degrees
	localparam logic signed [WRAP_W-1:0] Q8_DEG180 = 20'sd46080;
	localparam logic signed [WRAP_W-1:0] Q8_DEG360 = 20'sd92160;
	localparam logic signed [WRAP_W-1:0] Q8_DEG170 = 20'sd43520;
	localparam logic signed [ERR_W-1:0]  Q8_DEG10  = 18'sd2560;
	localparam logic signed [ERR_W-1:0]  Q8_DEG0P2 = 18'sd51;
	localparam logic signed [SUM_W:0]    Q8_DEG50  = 16'sd12800;

	// 57.2957795 * 256 / 4096 in Q16
	localparam logic signed [MUL_B_W-1:0] RAD_TO_DEG_Q16 = 19'sd234684;

	// Rounding offsets for the two final shifts
	localparam int RATE_SHIFT = 16;
	localparam int OUT_SHIFT  = 8;
	localparam logic signed [ACC_W-1:0] RATE_RND = ACC_W'(64'sd1 <<< (RATE_SHIFT - 1));
	localparam logic signed [ACC_W-1:0] OUT_RND  = ACC_W'(64'sd1 <<< (OUT_SHIFT - 1));

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN  = 2'd0,
		REG_INTEG_GAIN = 2'd1,
		REG_DERIV_GAIN = 2'd2,
		REG_GYRO_BIAS  = 2'd3
	} cfg_reg_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RATE_MUL,
		ST_ERR,
		ST_RATE,
		ST_P_ACC,
		ST_I_ACC,
		ST_D_ACC,
		ST_WB
	} seq_state_t;

	// Control of the shared multiply-accumulate unit
	typedef struct packed {
		logic mul_en;
		logic acc_en;
		logic acc_clr;
		logic acc_sub;
	} mac_ctrl_t;

	// Saturate a wide signed value to the output width
	function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
		logic all_one;
		logic all_zero;
		all_one  = &v[ACC_W-1:OUT_W-1];
		all_zero = ~|v[ACC_W-1:OUT_W-1];
		if (all_one || all_zero)
			return v[OUT_W-1:0];
		else if (v[ACC_W-1])
			return {1'b1, {(OUT_W-1){1'b0}}};
		else
			return {1'b0, {(OUT_W-1){1'b1}}};
	endfunction

endpackage

// ----- sv/yao_if.sv -----
// ----------------------------------------------------------------------------
// Yaw angle outer loop channels
// Valid/ready channels for the tick item and the result item.
// ----------------------------------------------------------------------------
interface yao_tick_if;
	import yao_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [YAW_W-1:0]  yaw_measured;
	logic signed [GYRO_W-1:0] gyro_rate;
	logic signed [STEP_W-1:0] target_step;
	logic                     follow_mode;
	logic                     vision_lock;

	modport source (
		output valid, yaw_measured, gyro_rate, target_step, follow_mode, vision_lock,
		input  ready
	);
	modport sink (
		input  valid, yaw_measured, gyro_rate, target_step, follow_mode, vision_lock,
		output ready
	);
endinterface

interface yao_result_if;
	import yao_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] rate_setpoint;
	logic signed [ERR_W-1:0] wrapped_error;
	logic signed [OUT_W-1:0] rate_dps;

	modport source (
		output valid, rate_setpoint, wrapped_error, rate_dps,
		input  ready
	);
	modport sink (
		input  valid, rate_setpoint, wrapped_error, rate_dps,
		output ready
	);
endinterface

// ----- sv/yao_mac.sv -----
// ----------------------------------------------------------------------------
// Yaw angle outer loop multiply-accumulate unit
// One signed multiplier with a registered product, followed by an
// add/subtract accumulator.
// ----------------------------------------------------------------------------
module yao_mac (
	input  logic                                clk,
	input  yao_pkg::mac_ctrl_t                  ctrl,
	input  logic signed [yao_pkg::MUL_A_W-1:0]  op_a,
	input  logic signed [yao_pkg::MUL_B_W-1:0]  op_b,
	output logic signed [yao_pkg::ACC_W-1:0]    acc
);
	import yao_pkg::*;

	logic signed [ACC_W-1:0] prod_s1;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_base;

	// Register the product
	always_ff @(posedge clk) begin
		if (ctrl.mul_en)
			prod_s1 <= op_a * op_b;
	end

	// Start from zero or carry on from the running sum
	assign acc_base = ctrl.acc_clr ? '0 : acc_q;

	// Add or subtract the registered product
	always_ff @(posedge clk) begin
		if (ctrl.acc_en) begin
			if (ctrl.acc_sub)
				acc_q <= acc_base - prod_s1;
			else
				acc_q <= acc_base + prod_s1;
		end
	end

	assign acc = acc_q;

endmodule

// ----- sv/yaw_angle_outer_loop.sv -----
// ----------------------------------------------------------------------------
// Yaw angle outer loop
// Angle PI loop with wrap-around of target and error and a derivative term
// on the measured yaw rate, built around one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
//   tick   : one item per control tick (yaw, gyro rate, target step, follow
//            mode, vision lock); accepted when valid and ready are both high.
//   result : one item per tick (rate setpoint, wrapped error, yaw rate in
//            deg/s), held in an output register until taken.
//   cfg_*  : write gains and gyro bias while no tick is in progress.
// Sequencing:
//   A normal tick runs through seven sequencer steps, from the rate
//   multiply to the write-back step that loads the result register, set by
//   the single multiplier that forms the rate conversion and the P, I and D
//   products in turn. The next tick is taken in the idle state.
//   A follow-mode tick goes from idle straight to the write-back step and
//   loads an all-zero result there.
//   The block takes one tick at a time; the next tick is taken as soon as
//   the previous one has reached the output register, even if the receiver
//   has not yet taken it.
// Reset clears the gains, the bias, the yaw reference, the target and the
// error sum. While the receiver stalls, the finished result waits in the
// sequencer's write-back step and no further tick is accepted.
// ----------------------------------------------------------------------------
`include "yaw_angle_outer_loop_defines.svh"

module yaw_angle_outer_loop (
	input  logic                                clk,
	input  logic                                arst_n,
	yao_tick_if.sink                            tick,
	yao_result_if.source                        result,
	input  logic                                cfg_write,
	input  logic [yao_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [yao_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import yao_pkg::*;

	// Configuration
	logic [GAIN_W-1:0]        prop_gain_q;
	logic [GAIN_W-1:0]        integ_gain_q;
	logic [GAIN_W-1:0]        deriv_gain_q;
	logic signed [BIAS_W-1:0] gyro_bias_q;

	// Loop state
	logic signed [YAW_W-1:0] yaw_reference_q;
	logic signed [TGT_W-1:0] yaw_target_q;
	logic signed [SUM_W-1:0] error_sum_q;

	// Sequencer
	seq_state_t state_q;
	seq_state_t state_d;
	logic       follow_q;
	logic       out_valid_q;
	logic       out_load;
	logic       tick_accept;

	// Per-tick working registers
	logic signed [ANGLE_W-1:0] angle_q;
	logic signed [GYRO_W-1:0]  gyro_q;
	logic signed [STEP_W-1:0]  step_q;
	logic                      vision_q;
	logic signed [ERR_W-1:0]   err_q;
	logic signed [OUT_W-1:0]   rate_q;

	// Output register
	logic signed [OUT_W-1:0] setpoint_out_q;
	logic signed [ERR_W-1:0] error_out_q;
	logic signed [OUT_W-1:0] rate_out_q;

	// Shared unit
	mac_ctrl_t                 mac_ctrl;
	logic signed [MUL_A_W-1:0] op_a;
	logic signed [MUL_B_W-1:0] op_b;
	logic signed [ACC_W-1:0]   acc;

	// Datapath intermediates
	logic signed [ANGLE_W-1:0] angle_now;
	logic signed [GDIFF_W-1:0] gyro_diff;
	logic signed [WRAP_W-1:0]  tgt_pre;
	logic signed [WRAP_W-1:0]  tgt_wrap;
	logic signed [WRAP_W-1:0]  err_pre;
	logic signed [WRAP_W-1:0]  err_wrap;
	logic                      err_in_band;
	logic                      err_tiny;
	logic signed [SUM_W:0]     sum_ext;
	logic signed [SUM_W:0]     sum_add;
	logic signed [SUM_W:0]     sum_clamp;
	logic signed [SUM_W-1:0]   sum_next;
	logic signed [ACC_W-1:0]   rate_rnd;
	logic signed [ACC_W-1:0]   out_rnd;

	assign tick_accept = tick.valid && tick.ready;
	assign tick.ready  = (state_q == ST_IDLE);
	assign out_load    = (state_q == ST_WB) && (!out_valid_q || result.ready);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= '0;
			integ_gain_q <= '0;
			deriv_gain_q <= '0;
			gyro_bias_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PROP_GAIN:  prop_gain_q  <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN: integ_gain_q <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN: deriv_gain_q <= cfg_data[GAIN_W-1:0];
				REG_GYRO_BIAS:  gyro_bias_q  <= cfg_data[BIAS_W-1:0];
				default: ;
			endcase
		end
	end

	// Relative angle and bias-corrected gyro
	assign angle_now = ANGLE_W'(yaw_reference_q) - ANGLE_W'(tick.yaw_measured);
	assign gyro_diff = GDIFF_W'(gyro_q) - GDIFF_W'(gyro_bias_q);

	// Target: accumulate or snap, then wrap once into +-180
	always_comb begin
		if (vision_q)
			tgt_pre = WRAP_W'(angle_q);
		else
			tgt_pre = WRAP_W'(yaw_target_q) + WRAP_W'(step_q);
		priority if (tgt_pre > Q8_DEG180)
			tgt_wrap = tgt_pre - Q8_DEG360;
		else if (tgt_pre < -Q8_DEG180)
			tgt_wrap = tgt_pre + Q8_DEG360;
		else
			tgt_wrap = tgt_pre;
	end

	// Error: wrap once at +-170
	always_comb begin
		err_pre = tgt_wrap - WRAP_W'(angle_q);
		priority if (err_pre < -Q8_DEG170)
			err_wrap = err_pre + Q8_DEG360;
		else if (err_pre > Q8_DEG170)
			err_wrap = err_pre - Q8_DEG360;
		else
			err_wrap = err_pre;
	end

	// Integral: sum inside the band, clamp, drop near zero error
	assign sum_ext     = (SUM_W + 1)'(error_sum_q);
	assign err_in_band = (err_q < Q8_DEG10) && (err_q > -Q8_DEG10);
	assign err_tiny    = (err_q <= Q8_DEG0P2) && (err_q >= -Q8_DEG0P2);
	always_comb begin
		sum_add = err_in_band ? sum_ext + (SUM_W + 1)'(err_q) : sum_ext;
		priority if (sum_add > Q8_DEG50)
			sum_clamp = Q8_DEG50;
		else if (sum_add < -Q8_DEG50)
			sum_clamp = -Q8_DEG50;
		else
			sum_clamp = sum_add;
		sum_next = err_tiny ? '0 : sum_clamp[SUM_W-1:0];
	end

	// Rounding before the final shifts
	assign rate_rnd = (acc + RATE_RND) >>> RATE_SHIFT;
	assign out_rnd  = (acc + OUT_RND) >>> OUT_SHIFT;

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (tick.valid)
					state_d = tick.follow_mode ? ST_WB : ST_RATE_MUL;
			end
			ST_RATE_MUL: state_d = ST_ERR;
			ST_ERR:      state_d = ST_RATE;
			ST_RATE:     state_d = ST_P_ACC;
			ST_P_ACC:    state_d = ST_I_ACC;
			ST_I_ACC:    state_d = ST_D_ACC;
			ST_D_ACC:    state_d = ST_WB;
			ST_WB: begin
				if (!out_valid_q || result.ready)
					state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// Shared unit control and operand selection
	always_comb begin
		mac_ctrl = '0;
		op_a     = '0;
		op_b     = '0;
		unique case (state_q)
			ST_RATE_MUL: begin
				mac_ctrl.mul_en = 1'b1;
				op_a = MUL_A_W'(gyro_diff);
				op_b = RAD_TO_DEG_Q16;
			end
			ST_ERR: begin
				mac_ctrl.acc_en  = 1'b1;
				mac_ctrl.acc_clr = 1'b1;
			end
			ST_RATE: begin
				mac_ctrl.mul_en = 1'b1;
				op_a = MUL_A_W'(err_q);
				op_b = signed'(MUL_B_W'(prop_gain_q));
			end
			ST_P_ACC: begin
				mac_ctrl.acc_en  = 1'b1;
				mac_ctrl.acc_clr = 1'b1;
				mac_ctrl.mul_en  = 1'b1;
				op_a = MUL_A_W'(sum_ext);
				op_b = signed'(MUL_B_W'(integ_gain_q));
			end
			ST_I_ACC: begin
				mac_ctrl.acc_en = 1'b1;
				mac_ctrl.mul_en = 1'b1;
				op_a = MUL_A_W'(rate_q);
				op_b = signed'(MUL_B_W'(deriv_gain_q));
			end
			ST_D_ACC: begin
				mac_ctrl.acc_en  = 1'b1;
				mac_ctrl.acc_sub = 1'b1;
			end
			default: ;
		endcase
	end

	yao_mac u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.op_a (op_a),
		.op_b (op_b),
		.acc  (acc)
	);

	// Loop state: capture in follow mode, advance on a normal tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_reference_q <= '0;
			yaw_target_q    <= '0;
			error_sum_q     <= '0;
		end else if (tick_accept && tick.follow_mode) begin
			yaw_reference_q <= tick.yaw_measured;
			yaw_target_q    <= '0;
			error_sum_q     <= '0;
		end else if (state_q == ST_ERR) begin
			yaw_target_q <= tgt_wrap[TGT_W-1:0];
		end else if (state_q == ST_RATE) begin
			error_sum_q <= sum_next;
		end
	end

	// Follow flag of the tick in progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			follow_q <= 1'b0;
		else if (tick_accept)
			follow_q <= tick.follow_mode;
	end

	// Per-tick working registers
	always_ff @(posedge clk) begin
		if (tick_accept) begin
			angle_q  <= angle_now;
			gyro_q   <= tick.gyro_rate;
			step_q   <= tick.target_step;
			vision_q <= tick.vision_lock;
		end
		if (state_q == ST_ERR)
			err_q <= err_wrap[ERR_W-1:0];
		if (state_q == ST_RATE)
			rate_q <= sat_out(rate_rnd);
	end

	// Output valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (follow_q) begin
				setpoint_out_q <= '0;
				error_out_q    <= '0;
				rate_out_q     <= '0;
			end else begin
				setpoint_out_q <= sat_out(out_rnd);
				error_out_q    <= err_q;
				rate_out_q     <= rate_q;
			end
		end
	end

	assign result.valid         = out_valid_q;
	assign result.rate_setpoint = setpoint_out_q;
	assign result.wrapped_error = error_out_q;
	assign result.rate_dps      = rate_out_q;

	// Checks
	`YAO_ASSERT_ALWAYS(a_sum_clamped, clk, arst_n, (sum_ext <= Q8_DEG50) && (sum_ext >= -Q8_DEG50), "error sum outside +-50 degrees")
	`YAO_ASSERT_ALWAYS(a_target_wrapped, clk, arst_n, (WRAP_W'(yaw_target_q) <= Q8_DEG180) && (WRAP_W'(yaw_target_q) >= -Q8_DEG180), "target outside +-180 degrees")
	`YAO_ASSERT_NEXT(a_follow_clears, clk, arst_n, tick_accept && tick.follow_mode, (error_sum_q == '0) && (yaw_target_q == '0), "follow mode did not clear loop state")
	`YAO_ASSERT_NEXT(a_load_sets_valid, clk, arst_n, out_load, out_valid_q && (state_q == ST_IDLE), "result load did not raise valid")

endmodule

// ----- tb/yaw_angle_outer_loop_tb.sv -----
// ----------------------------------------------------------------------------
// Yaw angle outer loop testbench
// Drives control ticks through the valid/ready tick channel and predicts every
// result item with a cycle-free model of the angle loop (target and error
// wrap, windowed integral with clamp and clear, P+I-D with saturation). A
// short table of directed ticks comes first, then closed-loop random ticks
// under several gain and bias settings, with random idling on both channels,
// a long receiver hold-off and a full drain of the sender.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module yaw_angle_outer_loop_tb;
	import yao_pkg::*;

	// Angle and scaling constants, Q8 degrees
	localparam longint DEG_180    = 46080;
	localparam longint DEG_360    = 92160;
	localparam longint DEG_170    = 43520;
	localparam longint DEG_10     = 2560;
	localparam longint DEG_50     = 12800;
	localparam longint CLEAR_BAND = 51;
	localparam longint RAD_TO_DEG = 234684;
	localparam longint SAT_MAX    = 8388607;
	localparam longint SAT_MIN    = -8388608;

	localparam int DIRECTED_ROWS    = 23;
	localparam int PHASES           = 7;
	localparam int RANDOM_PER_PHASE = 215;
	localparam int HOLD_CYCLES      = 300;

	typedef struct {
		logic signed [YAW_W-1:0]  yaw;
		logic signed [GYRO_W-1:0] gyro;
		logic signed [STEP_W-1:0] step;
		logic                     follow;
		logic                     vision;
	} tick_t;

	typedef struct {
		logic signed [OUT_W-1:0] setpoint;
		logic signed [ERR_W-1:0] wrap_err;
		logic signed [OUT_W-1:0] rate;
	} result_t;

	// Directed row: tick fields, then a typed result where one is given
	typedef struct {
		int yaw;
		int gyro;
		int step;
		bit follow;
		bit vision;
		bit typed;
		int sp;
		int err;
		int rate;
	} stim_row_t;

	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{0, 0, 0, 1'b1, 1'b0, 1'b1, 0, 0, 0},          // capture zero reference
		'{0, 0, 0, 1'b0, 1'b0, 1'b1, 0, 0, 0},          // on target, no rate
		'{0, 524287, 2559, 1'b0, 1'b0, 1'b0, 0, 0, 0},  // just inside integral window
		'{0, -524288, 0, 1'b0, 1'b0, 1'b0, 0, 0, 0},
		'{0, 1000, 0, 1'b0, 1'b0, 1'b0, 0, 0, 0},
		'{0, 1000, 0, 1'b0, 1'b0, 1'b0, 0, 0, 0},
		'{0, 1000, 0, 1'b0, 1'b0, 1'b0, 0, 0, 0},
		'{0, 0, 0, 1'b0, 1'b0, 1'b0, 0, 0, 0},          // integral clamps at 50 deg
		'{0, 0, -2529, 1'b0, 1'b0, 1'b0, 0, 0, 0},      // small error clears integral
		'{65535, 0, 0, 1'b0, 1'b0, 1'b0, 0, 0, 0},      // yaw beyond range
		'{-65536, -1, 32767, 1'b0, 1'b0, 1'b0, 0, 0, 0},
		'{-65536, 0, -32768, 1'b0, 1'b1, 1'b0, 0, 0, 0}, // lock drops the step
		'{0, 0, 32767, 1'b0, 1'b0, 1'b0, 0, 0, 0},
		'{0, 0, 32767, 1'b0, 1'b0, 1'b0, 0, 0, 0},      // target rises to 38910, no wrap
		'{0, 0, -32768, 1'b0, 1'b0, 1'b0, 0, 0, 0},
		'{0, 0, -32768, 1'b0, 1'b0, 1'b0, 0, 0, 0},     // target falls to -26626, no wrap
		'{-65536, 0, 0, 1'b1, 1'b1, 1'b1, 0, 0, 0},     // follow wins over lock
		'{65535, 0, 0, 1'b0, 1'b0, 1'b0, 0, 0, 0},      // error back inside +-170 after one wrap
		'{65535, 0, 0, 1'b0, 1'b1, 1'b0, 0, 0, 0},      // lock on out-of-range angle
		'{46080, 0, 0, 1'b1, 1'b0, 1'b1, 0, 0, 0},
		'{-46080, -524288, -32768, 1'b0, 1'b0, 1'b0, 0, 0, 0},
		'{0, 0, 0, 1'b1, 1'b0, 1'b1, 0, 0, 0},
		'{0, 0, 0, 1'b0, 1'b1, 1'b1, 0, 0, 0}           // lock on own angle: zero error
	};

	// Fixed gain settings for the first random phases; the rest are random
	int phase_gains [5][4] = '{
		'{0, 0, 0, 0},
		'{65535, 65535, 65535, -524288},
		'{65535, 0, 0, 524287},
		'{0, 65535, 0, 0},
		'{0, 0, 65535, 1000}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	yao_tick_if   tick_ch ();
	yao_result_if result_ch ();

	yaw_angle_outer_loop u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick_ch),
		.result    (result_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Loop state and configuration as the block should hold them
	logic signed [YAW_W-1:0]  yaw_zero;
	logic signed [TGT_W-1:0]  target_acc;
	logic signed [SUM_W-1:0]  integral_acc;
	logic [GAIN_W-1:0]        prop_cfg;
	logic [GAIN_W-1:0]        integ_cfg;
	logic [GAIN_W-1:0]        deriv_cfg;
	logic signed [BIAS_W-1:0] bias_cfg;

	result_t loop_outputs_due [$];

	int  gap_pct = 18;
	bit  hold_request = 1'b0;
	int  mismatch_count = 0;
	int  ticks_accepted = 0;
	int  results_checked = 0;
	int  follow_ticks = 0;
	int  vision_ticks = 0;
	int  clamp_ticks = 0;
	int  clear_ticks = 0;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic longint clamp_24(input longint v);
		if (v > SAT_MAX)
			return SAT_MAX;
		if (v < SAT_MIN)
			return SAT_MIN;
		return v;
	endfunction

	// Advance the loop state by one tick and return the result it yields
	function automatic result_t predict_loop(input tick_t t);
		result_t r;
		longint  angle, target, err, sum, rate, total;
		if (t.follow) begin
			integral_acc = '0;
			target_acc   = '0;
			yaw_zero     = t.yaw;
			r.setpoint   = '0;
			r.wrap_err   = '0;
			r.rate       = '0;
			return r;
		end
		angle = longint'(yaw_zero) - longint'(t.yaw);
		rate  = clamp_24(((longint'(t.gyro) - longint'(bias_cfg)) * RAD_TO_DEG + 32768) >>> 16);

		// Accumulate or snap the target, then wrap once
		target = longint'(target_acc) + longint'(t.step);
		if (t.vision)
			target = angle;
		if (target > DEG_180)
			target -= DEG_360;
		else if (target < -DEG_180)
			target += DEG_360;

		err = target - angle;
		if (err < -DEG_170)
			err += DEG_360;
		else if (err > DEG_170)
			err -= DEG_360;

		// Windowed integral with clamp and dead band
		sum = longint'(integral_acc);
		if (err < DEG_10 && err > -DEG_10)
			sum += err;
		if (sum > DEG_50 || sum < -DEG_50)
			clamp_ticks++;
		if (sum > DEG_50)
			sum = DEG_50;
		if (sum < -DEG_50)
			sum = -DEG_50;
		if (err <= CLEAR_BAND && err >= -CLEAR_BAND) begin
			if (sum != 0)
				clear_ticks++;
			sum = 0;
		end

		total = err * longint'(prop_cfg) + sum * longint'(integ_cfg)
			- longint'(deriv_cfg) * rate;
		total = clamp_24((total + 128) >>> 8);

		target_acc   = TGT_W'(target);
		integral_acc = SUM_W'(sum);
		r.setpoint   = OUT_W'(total);
		r.wrap_err   = ERR_W'(err);
		r.rate       = OUT_W'(rate);
		return r;
	endfunction

	// Compare a result item with the oldest one due
	function automatic void check_output(input result_t got);
		result_t want;
		if (loop_outputs_due.size() == 0) begin
			$error("unexpected result item: rate_setpoint %0d wrapped_error %0d rate_dps %0d",
				got.setpoint, got.wrap_err, got.rate);
			mismatch_count++;
			return;
		end
		want = loop_outputs_due.pop_front();
		results_checked++;
		if (got.setpoint !== want.setpoint) begin
			$error("rate_setpoint: expected %0d, got %0d", want.setpoint, got.setpoint);
			mismatch_count++;
		end
		if (got.wrap_err !== want.wrap_err) begin
			$error("wrapped_error: expected %0d, got %0d", want.wrap_err, got.wrap_err);
			mismatch_count++;
		end
		if (got.rate !== want.rate) begin
			$error("rate_dps: expected %0d, got %0d", want.rate, got.rate);
			mismatch_count++;
		end
	endfunction

	// Build a random tick; most close the loop around a chosen error
	function automatic tick_t random_tick();
		tick_t  t;
		int     pick;
		longint want, stp;
		pick     = $urandom_range(99);
		t.follow = ($urandom_range(99) < 3);
		t.vision = ($urandom_range(99) < 5);
		if (pick < 10) begin
			t.yaw  = YAW_W'($urandom());
			t.gyro = GYRO_W'($urandom());
			t.step = STEP_W'($urandom());
		end else begin
			t.yaw  = YAW_W'(int'($urandom_range(92160)) - 46080);
			if (pick < 40)
				t.gyro = GYRO_W'(int'($urandom_range(4000)) - 2000);
			else
				t.gyro = GYRO_W'($urandom());
			if (pick < 75) begin
				if ($urandom_range(3) == 0)
					want = longint'(int'($urandom_range(120)) - 60);
				else
					want = longint'(int'($urandom_range(6000)) - 3000);
				stp = longint'(yaw_zero) - longint'(t.yaw) + want - longint'(target_acc);
				if (stp > 32767)
					stp = 32767;
				if (stp < -32768)
					stp = -32768;
				t.step = STEP_W'(stp);
			end else begin
				t.step = STEP_W'(int'($urandom_range(5120)) - 2560);
			end
		end
		return t;
	endfunction

	// Offer one tick, idling at random first; valid stays high on return
	task automatic send_tick(input tick_t t, input bit typed, input result_t typed_res);
		result_t due;
		while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tick_ch.valid        <= 1'b1;
		tick_ch.yaw_measured <= t.yaw;
		tick_ch.gyro_rate    <= t.gyro;
		tick_ch.target_step  <= t.step;
		tick_ch.follow_mode  <= t.follow;
		tick_ch.vision_lock  <= t.vision;
		do
			@(posedge clk);
		while (!tick_ch.ready);
		due = predict_loop(t);
		loop_outputs_due.push_back(typed ? typed_res : due);
		ticks_accepted++;
		if (t.follow)
			follow_ticks++;
		else if (t.vision)
			vision_ticks++;
	endtask

	// Drop valid and wait until every result has come back
	task automatic drain_outputs();
		tick_ch.valid <= 1'b0;
		while (loop_outputs_due.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic put_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_PROP_GAIN:  prop_cfg  = data[GAIN_W-1:0];
			REG_INTEG_GAIN: integ_cfg = data[GAIN_W-1:0];
			REG_DERIV_GAIN: deriv_cfg = data[GAIN_W-1:0];
			REG_GYRO_BIAS:  bias_cfg  = data;
		endcase
	endtask

	// Write all four registers; gain words carry random upper bits
	task automatic load_config(input int p, input int i, input int d, input int b);
		cfg_write <= 1'b1;
		put_register(REG_PROP_GAIN, {4'($urandom()), 16'(p)});
		put_register(REG_INTEG_GAIN, {4'($urandom()), 16'(i)});
		put_register(REG_DERIV_GAIN, {4'($urandom()), 16'(d)});
		put_register(REG_GYRO_BIAS, 20'(b));
		cfg_write <= 1'b0;
	endtask

	// Receive results, idling at random or holding off on request
	initial begin : result_sink
		result_t got;
		int      hold_left;
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				got.setpoint = result_ch.rate_setpoint;
				got.wrap_err = result_ch.wrapped_error;
				got.rate     = result_ch.rate_dps;
				check_output(got);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= (gap_pct == 0) || ($urandom_range(99) >= gap_pct);
			end
		end
	end

	initial begin : stimulus
		tick_t   t;
		result_t typed_res;
		int      p, i, d, b;

		arst_n               <= 1'b0;
		cfg_write            <= 1'b0;
		cfg_index            <= REG_PROP_GAIN;
		cfg_data             <= '0;
		tick_ch.valid        <= 1'b0;
		tick_ch.yaw_measured <= '0;
		tick_ch.gyro_rate    <= '0;
		tick_ch.target_step  <= '0;
		tick_ch.follow_mode  <= 1'b0;
		tick_ch.vision_lock  <= 1'b0;
		yaw_zero     = '0;
		target_acc   = '0;
		integral_acc = '0;
		prop_cfg     = '0;
		integ_cfg    = '0;
		deriv_cfg    = '0;
		bias_cfg     = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table under moderate gains
		load_config(384, 64, 16, 0);
		foreach (directed_rows[r]) begin
			t.yaw              = YAW_W'(directed_rows[r].yaw);
			t.gyro             = GYRO_W'(directed_rows[r].gyro);
			t.step             = STEP_W'(directed_rows[r].step);
			t.follow           = directed_rows[r].follow;
			t.vision           = directed_rows[r].vision;
			typed_res.setpoint = OUT_W'(directed_rows[r].sp);
			typed_res.wrap_err = ERR_W'(directed_rows[r].err);
			typed_res.rate     = OUT_W'(directed_rows[r].rate);
			send_tick(t, directed_rows[r].typed, typed_res);
		end
		drain_outputs();

		// Random phases, each under its own gain setting
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 5) begin
				p = phase_gains[ph][0];
				i = phase_gains[ph][1];
				d = phase_gains[ph][2];
				b = phase_gains[ph][3];
			end else begin
				p = $urandom_range(65535);
				i = $urandom_range(65535);
				d = $urandom_range(2047);
				b = int'($urandom_range(1048575)) - 524288;
			end
			load_config(p, i, d, b);
			gap_pct = (ph == 2) ? 0 : 18;
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (ph == 3 && n == 40)
					hold_request = 1'b1;
				if (ph == 4 && n == 100)
					drain_outputs();
				send_tick(random_tick(), 1'b0, typed_res);
			end
			drain_outputs();
		end

		repeat (20) @(posedge clk);
		$display("Run covered %0d ticks (%0d follow, %0d vision lock) over %0d gain settings.",
			ticks_accepted, follow_ticks, vision_ticks, PHASES + 1);
		$display("%0d results checked; integral clamped on %0d ticks, cleared on %0d.",
			results_checked, clamp_ticks, clear_ticks);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Guard against a hung handshake
	initial begin : watchdog
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
